@@ rtl/core/jpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpr_pkg
// Shared types, codes and helpers for the Jacobi polynomial recurrence core.
// ----------------------------------------------------------------------------
package jpr_pkg;

    localparam int unsigned MAX_DEGREE = 31;
    localparam int unsigned DEG_W      = 5;
    localparam int unsigned PARAM_W    = 21;
    localparam int unsigned X_W        = 26;
    localparam int unsigned VAL_W      = 64;
    localparam int unsigned NUM_W      = 128;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BETA  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TOP   = 2'd2;

    localparam logic [3:0] OP_P1  = 4'd0;
    localparam logic [3:0] OP_C1A = 4'd1;
    localparam logic [3:0] OP_C1B = 4'd2;
    localparam logic [3:0] OP_C2A = 4'd3;
    localparam logic [3:0] OP_C2B = 4'd4;
    localparam logic [3:0] OP_C3A = 4'd5;
    localparam logic [3:0] OP_C3B = 4'd6;
    localparam logic [3:0] OP_C4A = 4'd7;
    localparam logic [3:0] OP_C4B = 4'd8;
    localparam logic [3:0] OP_K   = 4'd9;
    localparam logic [3:0] OP_NA  = 4'd10;
    localparam logic [3:0] OP_NB  = 4'd11;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic       inc_j;
        logic       mul_start;
        logic       div_start;
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic j_zero;
        logic j_top;
        logic mul_done;
        logic div_done;
    } t_stat;

    // round to nearest (ties up), then arithmetic shift right
    function automatic logic signed [VAL_W-1:0] rsh(input logic signed [VAL_W-1:0] v,
                                                    input int unsigned sh);
        logic [VAL_W-1:0] u;
        u = v + (64'd1 << (sh - 1));
        return $signed(u) >>> sh;
    endfunction

endpackage

@@ rtl/core/jpr_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpr_mul
// Shared signed 64x64 multiplier, shift-and-add, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module jpr_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [jpr_pkg::VAL_W-1:0]    i_a,
    input  logic signed [jpr_pkg::VAL_W-1:0]    i_b,
    output logic                                o_done,
    output logic signed [jpr_pkg::NUM_W-1:0]    o_prod
);

    logic                       r_busy, r_fin, r_done, r_neg;
    logic [jpr_pkg::NUM_W-1:0]  r_ma, r_acc, r_prod;
    logic [jpr_pkg::VAL_W-1:0]  r_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && !r_busy && r_fin;
            if (i_start) begin
                r_ma   <= {64'd0, (i_a[63] ? 64'd0 - i_a : i_a)};
                r_mb   <= i_b[63] ? 64'd0 - i_b : i_b;
                r_acc  <= '0;
                r_neg  <= i_a[63] ^ i_b[63];
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_mb == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                end
            end else if (r_fin) begin
                r_prod <= r_neg ? '0 - r_acc : r_acc;
                r_fin  <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = $signed(r_prod);

endmodule

@@ rtl/core/jpr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpr_div
// 128/64 signed divider, restoring, one quotient bit a cycle, rounds half
// away from zero and clips to 64 bits.
// ----------------------------------------------------------------------------
module jpr_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [jpr_pkg::NUM_W-1:0]    i_num,
    input  logic signed [jpr_pkg::VAL_W-1:0]    i_den,
    output logic                                o_done,
    output logic signed [jpr_pkg::VAL_W-1:0]    o_quot,
    output logic                                o_sat
);

    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                       r_prep, r_busy, r_fin, r_done, r_neg, r_sat;
    logic [jpr_pkg::NUM_W-1:0]  r_dq;
    logic [jpr_pkg::VAL_W-1:0]  r_d, r_rem, r_quot;
    logic [6:0]                 r_cnt;
    logic [64:0]                w_rem2, w_diff;
    logic                       w_ge;

    assign w_rem2 = {r_rem, r_dq[127]};
    assign w_ge   = w_rem2 >= {1'b0, r_d};
    assign w_diff = w_rem2 - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep <= 1'b0;
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            r_done <= i_start ? (i_den == '0) : (!r_prep && !r_busy && r_fin);
            if (i_start) begin
                if (i_den == '0) begin
                    r_quot <= (i_num == '0) ? 64'd0 : (i_num[127] ? S64_MIN : S64_MAX);
                    r_sat  <= i_num != '0;
                end else begin
                    r_dq   <= i_num[127] ? '0 - i_num : i_num;
                    r_d    <= i_den[63] ? 64'd0 - i_den : i_den;
                    r_neg  <= i_num[127] ^ i_den[63];
                    r_prep <= 1'b1;
                end
            end else if (r_prep) begin
                r_dq   <= r_dq + {65'd0, r_d[63:1]};
                r_rem  <= '0;
                r_cnt  <= '0;
                r_prep <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[63:0] : w_rem2[63:0];
                r_dq  <= {r_dq[126:0], w_ge};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(jpr_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                if (r_neg) begin
                    if (r_dq[127:64] != '0 || r_dq[63:0] > S64_MIN) begin
                        r_quot <= S64_MIN;
                        r_sat  <= 1'b1;
                    end else begin
                        r_quot <= 64'd0 - r_dq[63:0];
                        r_sat  <= 1'b0;
                    end
                end else begin
                    if (r_dq[127:64] != '0 || r_dq[63]) begin
                        r_quot <= S64_MAX;
                        r_sat  <= 1'b1;
                    end else begin
                        r_quot <= r_dq[63:0];
                        r_sat  <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = $signed(r_quot);
    assign o_sat  = r_sat;

endmodule

@@ rtl/core/jpr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpr_datapath
// Registers, coefficient terms, shared multiplier and divider, result register.
// ----------------------------------------------------------------------------
module jpr_datapath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [jpr_pkg::CFG_ADDR_W-1:0]          i_cfg_addr,
    input  logic [jpr_pkg::PARAM_W-1:0]             i_cfg_data,
    input  logic signed [jpr_pkg::X_W-1:0]          i_x,
    input  logic                                    i_last,
    input  jpr_pkg::t_cmd                           i_cmd,
    output jpr_pkg::t_stat                          o_stat,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    output logic [jpr_pkg::OUT_DATA_W-1:0]          o_m_tdata,
    output logic                                    o_m_tlast,
    output logic [1:0]                              o_m_tuser
);

    logic signed [20:0] r_alpha, r_beta;
    logic [4:0]         r_top, r_n, r_j, r_deg;
    logic signed [25:0] r_x;
    logic               r_last, r_sticky, r_m_valid, r_olast, r_obatch, r_osat;
    logic signed [63:0] r_prev, r_bpp, r_tmp, r_c1, r_c2, r_c3, r_c4, r_val;
    logic signed [127:0] r_num;

    logic signed [63:0] w_a, w_b, w_s, w_d, w_j, w_x;
    logic signed [63:0] w_js, w_2m2, w_2m1, w_2j, w_ua, w_ub;
    logic signed [63:0] w_ma, w_mb, w_lo, w_r16;
    logic signed [127:0] w_prod;
    logic signed [63:0] w_quot;
    logic               w_mdone, w_ddone, w_dsat, w_out_free;

    assign w_a   = {{43{r_alpha[20]}}, r_alpha};
    assign w_b   = {{43{r_beta[20]}}, r_beta};
    assign w_s   = w_a + w_b;
    assign w_d   = w_a - w_b;
    assign w_j   = {59'd0, r_j};
    assign w_x   = {{38{r_x[25]}}, r_x};
    assign w_js  = (w_j <<< 16) + w_s;
    assign w_2m2 = (((w_j <<< 1) - 64'sd2) <<< 16) + w_s;
    assign w_2m1 = (((w_j <<< 1) - 64'sd1) <<< 16) + w_s;
    assign w_2j  = ((w_j <<< 1) <<< 16) + w_s;
    assign w_ua  = ((w_j - 64'sd1) <<< 16) + w_a;
    assign w_ub  = ((w_j - 64'sd1) <<< 16) + w_b;

    always_comb begin
        w_ma = w_js;
        w_mb = w_2m2;
        unique case (i_cmd.op)
            jpr_pkg::OP_P1:  begin w_ma = (64'sd1 <<< 17) + w_s; w_mb = w_x;   end
            jpr_pkg::OP_C1A: begin w_ma = w_js;  w_mb = w_2m2;                 end
            jpr_pkg::OP_C1B: begin w_ma = r_tmp; w_mb = w_j <<< 1;             end
            jpr_pkg::OP_C2A: begin w_ma = w_2m1; w_mb = w_2j;                  end
            jpr_pkg::OP_C2B: begin w_ma = r_tmp; w_mb = w_2m2;                 end
            jpr_pkg::OP_C3A: begin w_ma = w_2m1; w_mb = w_s;                   end
            jpr_pkg::OP_C3B: begin w_ma = r_tmp; w_mb = w_d;                   end
            jpr_pkg::OP_C4A: begin w_ma = w_ua;  w_mb = w_ub;                  end
            jpr_pkg::OP_C4B: begin w_ma = r_tmp; w_mb = w_2j;                  end
            jpr_pkg::OP_K:   begin w_ma = r_c2;  w_mb = w_x;                   end
            jpr_pkg::OP_NA:  begin w_ma = r_c3;  w_mb = r_prev;                end
            jpr_pkg::OP_NB:  begin w_ma = r_c4;  w_mb = r_bpp;                 end
            default:         begin w_ma = w_js;  w_mb = w_2m2;                 end
        endcase
    end

    jpr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    jpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_c1),
        .o_done  (w_ddone),
        .o_quot  (w_quot),
        .o_sat   (w_dsat)
    );

    assign w_lo       = w_prod[63:0];
    assign w_r16      = jpr_pkg::rsh(w_lo, 16);
    assign w_out_free = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= '0;
            r_beta    <= '0;
            r_top     <= '0;
            r_n       <= '0;
            r_j       <= '0;
            r_prev    <= '0;
            r_bpp     <= '0;
            r_sticky  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    jpr_pkg::REG_ALPHA: r_alpha <= $signed(i_cfg_data);
                    jpr_pkg::REG_BETA:  r_beta  <= $signed(i_cfg_data);
                    jpr_pkg::REG_TOP:   r_top   <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_x      <= i_x;
                r_last   <= i_last;
                r_n      <= (r_top > 5'(jpr_pkg::MAX_DEGREE)) ? 5'(jpr_pkg::MAX_DEGREE) : r_top;
                r_j      <= '0;
                r_prev   <= 64'sd1 <<< 24;
                r_bpp    <= '0;
                r_sticky <= 1'b0;
            end
            if (i_cmd.inc_j) begin
                r_j <= r_j + 5'd1;
            end
            if (w_mdone) begin
                case (i_cmd.op) inside
                    jpr_pkg::OP_P1: begin
                        r_prev <= jpr_pkg::rsh(w_lo + (w_d <<< 24), 17);
                        r_bpp  <= r_prev;
                        r_j    <= 5'd1;
                    end
                    jpr_pkg::OP_C1A, jpr_pkg::OP_C2A,
                    jpr_pkg::OP_C3A, jpr_pkg::OP_C4A: r_tmp <= w_r16;
                    jpr_pkg::OP_C1B: r_c1  <= w_lo;
                    jpr_pkg::OP_C2B: r_c2  <= w_r16;
                    jpr_pkg::OP_C3B: r_c3  <= w_r16;
                    jpr_pkg::OP_C4B: r_c4  <= 64'sd0 - (w_r16 <<< 1);
                    jpr_pkg::OP_K:   r_c3  <= r_c3 + jpr_pkg::rsh(w_lo, 24);
                    jpr_pkg::OP_NA:  r_num <= w_prod;
                    jpr_pkg::OP_NB:  r_num <= r_num + w_prod;
                    default: ;
                endcase
            end
            if (w_ddone) begin
                r_bpp    <= r_prev;
                r_prev   <= w_quot;
                r_sticky <= r_sticky | w_dsat;
            end
            if (i_cmd.emit) begin
                r_m_valid <= 1'b1;
                r_val     <= r_prev;
                r_deg     <= r_j;
                r_olast   <= r_j == r_n;
                r_obatch  <= r_last;
                r_osat    <= r_sticky;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = w_out_free;
    assign o_stat.j_zero   = r_j == '0;
    assign o_stat.j_top    = r_j == r_n;
    assign o_stat.mul_done = w_mdone;
    assign o_stat.div_done = w_ddone;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {3'b000, r_deg, r_val};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = {r_osat, r_obatch};

endmodule

@@ rtl/core/jpr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpr_ctrl
// Sequencer: per point emits degree 0, runs P1 if the top degree is not 0,
// then per higher degree eleven multiplies, one divide and a result request.
// ----------------------------------------------------------------------------
module jpr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  jpr_pkg::t_stat  i_stat,
    output jpr_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EMIT   = 3'd1;
    localparam logic [2:0] S_MSTART = 3'd2;
    localparam logic [2:0] S_MWAIT  = 3'd3;
    localparam logic [2:0] S_DSTART = 3'd4;
    localparam logic [2:0] S_DWAIT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [3:0] r_op, n_op;

    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        o_cmd           = '0;
        o_cmd.op        = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.j_top) begin
                        n_state = S_IDLE;
                    end else if (i_stat.j_zero) begin
                        n_op    = jpr_pkg::OP_P1;
                        n_state = S_MSTART;
                    end else begin
                        o_cmd.inc_j = 1'b1;
                        n_op        = jpr_pkg::OP_C1A;
                        n_state     = S_MSTART;
                    end
                end
            end
            S_MSTART: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_stat.mul_done) begin
                    if (r_op == jpr_pkg::OP_P1) begin
                        n_state = S_EMIT;
                    end else if (r_op == jpr_pkg::OP_NB) begin
                        n_state = S_DSTART;
                    end else begin
                        n_op    = r_op + 4'd1;
                        n_state = S_MSTART;
                    end
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= jpr_pkg::OP_P1;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_s_tready = r_state == S_IDLE;

    a_start_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_start |=> !o_cmd.mul_start)
        else $error("multiply start held");
    a_mul_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.mul_done |-> r_state == S_MWAIT)
        else $error("multiply done outside wait");
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> r_state == S_DWAIT)
        else $error("divide done outside wait");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result overwritten");

endmodule

@@ rtl/core/jacobi_polynomial_recurrence_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_polynomial_recurrence_core
// Emits Jacobi polynomial values P0..Pn at each input point x.
//
//   port group  dir  fields (low bit up)
//   s (input)   in   tdata: x_point[25:0]; tlast: last_point
//   m (result)  out  tdata: poly_value[63:0], degree_index[68:64];
//                    tlast: last_degree; tuser: last_of_batch, saturated
//   cfg         in   addr 0 alpha_q16, 1 beta_q16, 2 top_degree
//
// Degree 0 is presented after the load, once the result register is free;
// degree 1 needs one multiply by x. Each higher degree runs eleven
// multiplies on one shift-add unit and a 128-step divide.
// A new point is taken only once the previous point's last degree is issued.
// A stalled result register holds the sequencer at its next result.
// Reset is synchronous, active low, and clears all control state.
// ----------------------------------------------------------------------------
module jacobi_polynomial_recurrence_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [jpr_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [jpr_pkg::PARAM_W-1:0]         i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [jpr_pkg::IN_DATA_W-1:0]       i_s_tdata,  // x_point[25:0]
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [jpr_pkg::OUT_DATA_W-1:0]      o_m_tdata,  // poly_value, degree_index
    output logic                                o_m_tlast,
    output logic [1:0]                          o_m_tuser   // last_of_batch, saturated
);

    jpr_pkg::t_cmd  w_cmd;
    jpr_pkg::t_stat w_stat;

    jpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    jpr_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_x        ($signed(i_s_tdata[25:0])),
        .i_last     (i_s_tlast),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
